### design/rgbyuv_pkg.sv
// Shared types and constants for the RGB to YUV matrix converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package rgbyuv_pkg;

   // Pixel component and pass-through byte width
   localparam int PIXEL_BITS         = 8;
   // Default width of one signed matrix coefficient
   localparam int COEFF_BITS_DEFAULT = 16;
   // Width of the signed per-channel offset
   localparam int OFFSET_BITS        = 21;
   // Arithmetic right shift applied to each sum
   localparam int OUT_SHIFT          = 8;
   // Only the bits up to the top of the kept output byte affect the result
   localparam int SUM_BITS           = OUT_SHIFT + PIXEL_BITS;
   // Register bits at or above this position always read as zero
   localparam int REG_LIMIT_BITS     = 64;
   // Configuration register index width
   localparam int CSR_INDEX_BITS     = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_Y_ROW_COEFFS = 3'd0,
      CSR_U_ROW_COEFFS = 3'd1,
      CSR_V_ROW_COEFFS = 3'd2,
      CSR_Y_OFFSET     = 3'd3,
      CSR_U_OFFSET     = 3'd4,
      CSR_V_OFFSET     = 3'd5
   } csr_index_type;

   // One pixel as held in the input register
   typedef struct packed {
      logic [PIXEL_BITS-1:0] lead_byte;
      logic [PIXEL_BITS-1:0] red;
      logic [PIXEL_BITS-1:0] green;
      logic [PIXEL_BITS-1:0] blue;
      logic                  row_end;
   } pixel_type;

   // One converted pixel as held in the result register
   typedef struct packed {
      logic [PIXEL_BITS-1:0] lead_byte;
      logic [PIXEL_BITS-1:0] luma;
      logic [PIXEL_BITS-1:0] chroma_u;
      logic [PIXEL_BITS-1:0] chroma_v;
      logic                  row_end;
   } result_type;

endpackage

`default_nettype wire

### design/rgbyuv_csr.sv
// Configuration registers: three coefficient rows and three offsets.
// Depends on rgbyuv_pkg.
`default_nettype none

module rgbyuv_csr #(
   parameter int COEFF_BITS = rgbyuv_pkg::COEFF_BITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [rgbyuv_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [3*COEFF_BITS-1:0]                csr_wdata,
   output      logic [3*COEFF_BITS-1:0]                y_row,
   output      logic [3*COEFF_BITS-1:0]                u_row,
   output      logic [3*COEFF_BITS-1:0]                v_row,
   output      logic [rgbyuv_pkg::OFFSET_BITS-1:0]     y_off,
   output      logic [rgbyuv_pkg::OFFSET_BITS-1:0]     u_off,
   output      logic [rgbyuv_pkg::OFFSET_BITS-1:0]     v_off
);
   import rgbyuv_pkg::*;

   localparam int ROW_BITS = 3 * COEFF_BITS;

   logic [ROW_BITS-1:0]    row_keep;
   logic [ROW_BITS-1:0]    row_wdata;
   logic [OFFSET_BITS-1:0] off_wdata;

   logic [ROW_BITS-1:0]    y_row_ff, y_row_in;
   logic [ROW_BITS-1:0]    u_row_ff, u_row_in;
   logic [ROW_BITS-1:0]    v_row_ff, v_row_in;
   logic [OFFSET_BITS-1:0] y_off_ff, y_off_in;
   logic [OFFSET_BITS-1:0] u_off_ff, u_off_in;
   logic [OFFSET_BITS-1:0] v_off_ff, v_off_in;

   // Drop row bits above bit 63: they always read as zero
   for (genvar i = 0; i < ROW_BITS; i++) begin : g_keep
      assign row_keep[i] = (i < REG_LIMIT_BITS) ? 1'b1 : 1'b0;
   end

   assign row_wdata = csr_wdata & row_keep;
   assign off_wdata = csr_wdata[OFFSET_BITS-1:0];
   assign csr_ready = 1'b1;

   // Decode the register index; writes beyond the list are ignored
   always_comb begin
      y_row_in = y_row_ff;
      u_row_in = u_row_ff;
      v_row_in = v_row_ff;
      y_off_in = y_off_ff;
      u_off_in = u_off_ff;
      v_off_in = v_off_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_Y_ROW_COEFFS: y_row_in = row_wdata;
            CSR_U_ROW_COEFFS: u_row_in = row_wdata;
            CSR_V_ROW_COEFFS: v_row_in = row_wdata;
            CSR_Y_OFFSET:     y_off_in = off_wdata;
            CSR_U_OFFSET:     u_off_in = off_wdata;
            CSR_V_OFFSET:     v_off_in = off_wdata;
            default: begin
            end
         endcase
      end
   end

   // Hold the registers, clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         y_row_ff <= '0;
         u_row_ff <= '0;
         v_row_ff <= '0;
         y_off_ff <= '0;
         u_off_ff <= '0;
         v_off_ff <= '0;
      end else begin
         y_row_ff <= y_row_in;
         u_row_ff <= u_row_in;
         v_row_ff <= v_row_in;
         y_off_ff <= y_off_in;
         u_off_ff <= u_off_in;
         v_off_ff <= v_off_in;
      end
   end

   assign y_row = y_row_ff;
   assign u_row = u_row_ff;
   assign v_row = v_row_ff;
   assign y_off = y_off_ff;
   assign u_off = u_off_ff;
   assign v_off = v_off_ff;

endmodule

`default_nettype wire

### design/rgbyuv_dot.sv
// One output channel: three coefficient products plus offset, shifted by 8.
// Depends on rgbyuv_pkg.
`default_nettype none

module rgbyuv_dot #(
   parameter int COEFF_BITS = rgbyuv_pkg::COEFF_BITS_DEFAULT
) (
   input  wire logic [3*COEFF_BITS-1:0]               row,
   input  wire logic [rgbyuv_pkg::OFFSET_BITS-1:0]    offset,
   input  wire logic [rgbyuv_pkg::PIXEL_BITS-1:0]     red,
   input  wire logic [rgbyuv_pkg::PIXEL_BITS-1:0]     green,
   input  wire logic [rgbyuv_pkg::PIXEL_BITS-1:0]     blue,
   output      logic [rgbyuv_pkg::PIXEL_BITS-1:0]     result
);
   import rgbyuv_pkg::*;

   logic [PIXEL_BITS-1:0]    comp  [3];
   logic signed [COEFF_BITS-1:0] coeff [3];
   logic [SUM_BITS-1:0]      coeff_ext [3];
   logic [SUM_BITS-1:0]      prod  [3];
   logic [SUM_BITS-1:0]      sum;

   assign comp[0] = red;
   assign comp[1] = green;
   assign comp[2] = blue;

   // Sign-extend or trim each coefficient to the sum width and multiply;
   // bits above the kept byte never reach the result, so wrap there
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         coeff[k]     = row[k*COEFF_BITS +: COEFF_BITS];
         coeff_ext[k] = SUM_BITS'(coeff[k]);
         prod[k]      = SUM_BITS'(coeff_ext[k] * SUM_BITS'(comp[k]));
      end
   end

   // Add the offset and take the byte above the shift
   assign sum    = prod[0] + prod[1] + prod[2] + offset[SUM_BITS-1:0];
   assign result = sum[SUM_BITS-1 -: PIXEL_BITS];

endmodule

`default_nettype wire

### design/rgb_to_yuv_matrix_converter_top.sv
// RGB to YUV converter: input register, three matrix rows, result register.
// Path: a transaction accepted into the input register passes to the result register and is then offered on rsp.
// Throughput: one pixel per cycle, set by the single arithmetic stage between
// the input and result registers; rsp_stall holds both stages.
// Reset: stage valids drop and all configuration registers clear to zero.
// Depends on rgbyuv_pkg, rgbyuv_csr and rgbyuv_dot.
`default_nettype none

module rgb_to_yuv_matrix_converter_top #(
   parameter int COEFF_BITS = rgbyuv_pkg::COEFF_BITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Pixel input
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic [rgbyuv_pkg::PIXEL_BITS-1:0]      req_lead_byte_in,
   input  wire logic [rgbyuv_pkg::PIXEL_BITS-1:0]      req_red,
   input  wire logic [rgbyuv_pkg::PIXEL_BITS-1:0]      req_green,
   input  wire logic [rgbyuv_pkg::PIXEL_BITS-1:0]      req_blue,
   input  wire logic                                   req_row_end_in,
   // Converted output
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic [rgbyuv_pkg::PIXEL_BITS-1:0]      rsp_lead_byte_out,
   output      logic [rgbyuv_pkg::PIXEL_BITS-1:0]      rsp_luma,
   output      logic [rgbyuv_pkg::PIXEL_BITS-1:0]      rsp_chroma_u,
   output      logic [rgbyuv_pkg::PIXEL_BITS-1:0]      rsp_chroma_v,
   output      logic                                   rsp_row_end_out,
   // Configuration writes
   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [rgbyuv_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [3*COEFF_BITS-1:0]                csr_wdata
);
   import rgbyuv_pkg::*;

   localparam int ROW_BITS = 3 * COEFF_BITS;

   logic [ROW_BITS-1:0]    y_row, u_row, v_row;
   logic [OFFSET_BITS-1:0] y_off, u_off, v_off;

   logic       in_valid_ff, in_valid_in;
   pixel_type  in_pix_ff, in_pix_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff, out_res_in;

   logic       out_free;
   logic       in_free;
   logic [PIXEL_BITS-1:0] luma, chroma_u, chroma_v;

   rgbyuv_csr #(.COEFF_BITS(COEFF_BITS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .y_row     (y_row),
      .u_row     (u_row),
      .v_row     (v_row),
      .y_off     (y_off),
      .u_off     (u_off),
      .v_off     (v_off)
   );

   // Handshake: the result register frees when empty or taken
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_free   = !in_valid_ff || out_free;
   assign req_stall = !in_free;

   // Input register: load on accepted transaction, drain into result stage
   always_comb begin
      in_valid_in = in_valid_ff;
      in_pix_in   = in_pix_ff;
      if (in_free) begin
         in_valid_in         = req_valid;
         in_pix_in.lead_byte = req_lead_byte_in;
         in_pix_in.red       = req_red;
         in_pix_in.green     = req_green;
         in_pix_in.blue      = req_blue;
         in_pix_in.row_end   = req_row_end_in;
      end
   end

   // Matrix rows
   rgbyuv_dot #(.COEFF_BITS(COEFF_BITS)) u_dot_y (
      .row    (y_row),
      .offset (y_off),
      .red    (in_pix_ff.red),
      .green  (in_pix_ff.green),
      .blue   (in_pix_ff.blue),
      .result (luma)
   );

   rgbyuv_dot #(.COEFF_BITS(COEFF_BITS)) u_dot_u (
      .row    (u_row),
      .offset (u_off),
      .red    (in_pix_ff.red),
      .green  (in_pix_ff.green),
      .blue   (in_pix_ff.blue),
      .result (chroma_u)
   );

   rgbyuv_dot #(.COEFF_BITS(COEFF_BITS)) u_dot_v (
      .row    (v_row),
      .offset (v_off),
      .red    (in_pix_ff.red),
      .green  (in_pix_ff.green),
      .blue   (in_pix_ff.blue),
      .result (chroma_v)
   );

   // Result register: advance when free, otherwise hold
   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (out_free) begin
         out_valid_in         = in_valid_ff;
         out_res_in.lead_byte = in_pix_ff.lead_byte;
         out_res_in.luma      = luma;
         out_res_in.chroma_u  = chroma_u;
         out_res_in.chroma_v  = chroma_v;
         out_res_in.row_end   = in_pix_ff.row_end;
      end
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      in_pix_ff  <= in_pix_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_lead_byte_out = out_res_ff.lead_byte;
   assign rsp_luma          = out_res_ff.luma;
   assign rsp_chroma_u      = out_res_ff.chroma_u;
   assign rsp_chroma_v      = out_res_ff.chroma_v;
   assign rsp_row_end_out   = out_res_ff.row_end;

endmodule

`default_nettype wire
